### hdl/rth_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// No dependencies; every other file but rth_div_step refers to this package by scoped names.
package rth_pkg;

   localparam int CHAN_W    = 8;
   localparam int SUM_W     = 9;
   localparam int HUE_W     = 9;
   localparam int PCT_W     = 7;

   // hue division: round(num/d) as floor((2*num + d) / (2*d))
   localparam int HUE_REM_W = 18;
   localparam int HUE_DIV_W = 9;
   localparam int HUE_Q_W   = 9;

   // saturation division: round(100*d/den) as floor((200*d + den) / (2*den))
   localparam int SAT_REM_W = 16;
   localparam int SAT_DIV_W = 9;
   localparam int SAT_Q_W   = 7;

   localparam logic [16:0] HUE_STEP       = 17'd60;
   localparam logic [16:0] HUE_GREEN_BASE = 17'd120;
   localparam logic [16:0] HUE_BLUE_BASE  = 17'd240;
   localparam logic [16:0] HUE_WRAP       = 17'd360;
   localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;

   localparam logic [SUM_W-1:0] CHAN_MAX  = 9'd255;
   localparam logic [SUM_W-1:0] SUM_MAX   = 9'd510;
   localparam logic [SAT_REM_W-1:0] SAT_SCALE = 16'd200;
   localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;

   // round(100*sum/510) = floor((20*sum + 51) / 102); 1/102 by reciprocal,
   // exact over the whole range of sum
   localparam int LIT_X_W    = 14;
   localparam int LIT_PROD_W = 27;
   localparam int LIT_SHIFT  = 20;
   localparam logic [LIT_X_W-1:0]    LIT_SCALE = 14'd20;
   localparam logic [LIT_X_W-1:0]    LIT_BIAS  = 14'd51;
   localparam logic [LIT_PROD_W-1:0] LIT_RECIP = 27'd10281;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // after max/min search
   typedef struct packed {
      sector_type        sector;
      logic              neg;
      logic [CHAN_W-1:0] mag;
      logic [CHAN_W-1:0] spread;
      logic [SUM_W-1:0]  sum;
   } prep_type;

   // one lane of the divider pipeline, carrying both divisions
   typedef struct packed {
      logic                 grey;
      logic [HUE_REM_W-1:0] hue_rem;
      logic [HUE_DIV_W-1:0] hue_div;
      logic [HUE_Q_W-1:0]   hue_q;
      logic [SAT_REM_W-1:0] sat_rem;
      logic [SAT_DIV_W-1:0] sat_div;
      logic [SAT_Q_W-1:0]   sat_q;
      logic [PCT_W-1:0]     lightness;
   } lane_type;

endpackage

### hdl/rth_div_step.sv
// One restoring division step: subtract the divisor shifted by a fixed amount.
// Purely combinational; no package dependency.
module rth_div_step #(
   parameter int REM_W = 18,
   parameter int DIV_W = 9,
   parameter int SHIFT = 0
) (
   input  logic [REM_W-1:0] rem,
   input  logic [DIV_W-1:0] div,
   output logic [REM_W-1:0] rem_next,
   output logic             q_bit
);

   localparam int CMP_W = (DIV_W + SHIFT > REM_W) ? DIV_W + SHIFT : REM_W;

   logic [CMP_W-1:0] rem_w;
   logic [CMP_W-1:0] trial;

   assign rem_w    = CMP_W'(rem);
   assign trial    = CMP_W'(div) << SHIFT;
   assign q_bit    = (rem_w >= trial);
   assign rem_next = q_bit ? REM_W'(rem_w - trial) : rem;

endmodule

### hdl/rth_prep.sv
// Front end: max/min search and sector pick, then dividends, divisors and lightness.
// Two register stages; depends on rth_pkg.
module rth_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        red,
   input  logic [7:0]        green,
   input  logic [7:0]        blue,
   output logic              out_valid,
   input  logic              out_ready,
   output rth_pkg::lane_type out_data
);

   logic              s1_valid_ff, s1_valid_in, s1_adv;
   rth_pkg::prep_type s1_ff, s1_in;
   logic              s2_valid_ff, s2_valid_in, s2_adv;
   rth_pkg::lane_type s2_ff, s2_in;

   logic ge_rg, ge_rb, ge_gb, ge_br, ge_gr, ge_bg;
   logic [7:0] mag_gb, mag_br, mag_rg, hi, lo;

   logic [16:0] spread17, mag17, hue_base, hue_num;
   logic [8:0]  den9;
   logic [rth_pkg::LIT_X_W-1:0]    lit_x;
   logic [rth_pkg::LIT_PROD_W-1:0] lit_prod;

   // a stage moves on when empty or when the next one moves
   assign s2_adv      = !s2_valid_ff || out_ready;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign in_ready    = s1_adv;
   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   // stage 1: largest channel, smallest channel, sector
   assign ge_rg  = (red >= green);
   assign ge_rb  = (red >= blue);
   assign ge_gb  = (green >= blue);
   assign ge_br  = (blue >= red);
   assign ge_gr  = (green >= red);
   assign ge_bg  = (blue >= green);
   assign mag_gb = ge_gb ? green - blue : blue - green;
   assign mag_br = ge_br ? blue - red : red - blue;
   assign mag_rg = ge_rg ? red - green : green - red;

   always_comb begin
      // ties go to red, then green
      if (ge_rg && ge_rb) begin
         s1_in.sector = rth_pkg::SECTOR_RED;
         hi           = red;
         s1_in.neg    = !ge_gb;
         s1_in.mag    = mag_gb;
      end else if (ge_gb) begin
         s1_in.sector = rth_pkg::SECTOR_GREEN;
         hi           = green;
         s1_in.neg    = !ge_br;
         s1_in.mag    = mag_br;
      end else begin
         s1_in.sector = rth_pkg::SECTOR_BLUE;
         hi           = blue;
         s1_in.neg    = !ge_rg;
         s1_in.mag    = mag_rg;
      end
      lo           = (ge_gr && ge_br) ? red : (ge_bg ? green : blue);
      s1_in.spread = hi - lo;
      s1_in.sum    = {1'b0, hi} + {1'b0, lo};
   end

   // stage 2: hue numerator, saturation denominator, lightness
   assign spread17 = 17'(s1_ff.spread);
   assign mag17    = 17'(s1_ff.mag);

   always_comb begin
      case (s1_ff.sector)
         rth_pkg::SECTOR_RED:   hue_base = s1_ff.neg ? spread17 * rth_pkg::HUE_WRAP : '0;
         rth_pkg::SECTOR_GREEN: hue_base = spread17 * rth_pkg::HUE_GREEN_BASE;
         default:               hue_base = spread17 * rth_pkg::HUE_BLUE_BASE;
      endcase
      hue_num = s1_ff.neg ? hue_base - mag17 * rth_pkg::HUE_STEP
                          : hue_base + mag17 * rth_pkg::HUE_STEP;
   end

   assign den9     = (s1_ff.sum <= rth_pkg::CHAN_MAX) ? s1_ff.sum
                                                      : rth_pkg::SUM_MAX - s1_ff.sum;
   assign lit_x    = rth_pkg::LIT_X_W'(s1_ff.sum) * rth_pkg::LIT_SCALE + rth_pkg::LIT_BIAS;
   assign lit_prod = rth_pkg::LIT_PROD_W'(lit_x) * rth_pkg::LIT_RECIP;

   always_comb begin
      s2_in.grey      = (s1_ff.spread == '0);
      s2_in.hue_rem   = {hue_num, 1'b0} + rth_pkg::HUE_REM_W'(s1_ff.spread);
      s2_in.hue_div   = {s1_ff.spread, 1'b0};
      s2_in.hue_q     = '0;
      s2_in.sat_rem   = rth_pkg::SAT_REM_W'(s1_ff.spread) * rth_pkg::SAT_SCALE
                      + rth_pkg::SAT_REM_W'(den9[7:0]);
      s2_in.sat_div   = {den9[7:0], 1'b0};
      s2_in.sat_q     = '0;
      s2_in.lightness = lit_prod[rth_pkg::LIT_SHIFT +: rth_pkg::PCT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) s1_ff <= s1_in;
      if (s2_adv) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

### hdl/rth_div_pipe.sv
// Pipelined restoring divider: one hue quotient bit per stage, and one saturation
// bit in each stage whose shift fits SAT_Q_W. Depends on rth_pkg and rth_div_step.
module rth_div_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rth_pkg::lane_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rth_pkg::lane_type out_data
);

   localparam int Stages = rth_pkg::HUE_Q_W;

   logic              valid_ff [Stages];
   rth_pkg::lane_type lane_ff  [Stages];
   rth_pkg::lane_type lane_in  [Stages];
   rth_pkg::lane_type src      [Stages];
   logic              src_valid [Stages];
   logic [Stages:0]   adv;

   assign adv[Stages] = out_ready;

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      localparam int Shift = Stages - 1 - k;

      logic [rth_pkg::HUE_REM_W-1:0] hue_rem_nx;
      logic                          hue_bit;
      logic [rth_pkg::SAT_REM_W-1:0] sat_rem_nx;
      logic [rth_pkg::SAT_Q_W-1:0]   sat_q_nx;

      if (k == 0) begin : g_head
         assign src[k]       = in_data;
         assign src_valid[k] = in_valid;
      end else begin : g_link
         assign src[k]       = lane_ff[k-1];
         assign src_valid[k] = valid_ff[k-1];
      end

      assign adv[k] = !valid_ff[k] || adv[k+1];

      rth_div_step #(
         .REM_W (rth_pkg::HUE_REM_W),
         .DIV_W (rth_pkg::HUE_DIV_W),
         .SHIFT (Shift)
      ) u_hue_step (
         .rem      (src[k].hue_rem),
         .div      (src[k].hue_div),
         .rem_next (hue_rem_nx),
         .q_bit    (hue_bit)
      );

      // saturation quotient is narrower, so its steps start later
      if (Shift < rth_pkg::SAT_Q_W) begin : g_sat
         logic sat_bit;

         rth_div_step #(
            .REM_W (rth_pkg::SAT_REM_W),
            .DIV_W (rth_pkg::SAT_DIV_W),
            .SHIFT (Shift)
         ) u_sat_step (
            .rem      (src[k].sat_rem),
            .div      (src[k].sat_div),
            .rem_next (sat_rem_nx),
            .q_bit    (sat_bit)
         );

         assign sat_q_nx = src[k].sat_q | (rth_pkg::SAT_Q_W'(sat_bit) << Shift);
      end else begin : g_sat_idle
         assign sat_rem_nx = src[k].sat_rem;
         assign sat_q_nx   = src[k].sat_q;
      end

      always_comb begin
         lane_in[k]         = src[k];
         lane_in[k].hue_rem = hue_rem_nx;
         lane_in[k].hue_q   = src[k].hue_q | (rth_pkg::HUE_Q_W'(hue_bit) << Shift);
         lane_in[k].sat_rem = sat_rem_nx;
         lane_in[k].sat_q   = sat_q_nx;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) lane_ff[k] <= lane_in[k];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = lane_ff[Stages-1];

   // quotients stay in range unless the spread is zero
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.grey |->
         out_data.hue_q <= rth_pkg::HUE_FULL && out_data.sat_q <= rth_pkg::PCT_MAX)
      else $error("divider quotient out of range");

   // enough steps ran: the remainder is below the divisor
   a_rem_final: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_data.grey |->
         out_data.hue_rem < rth_pkg::HUE_REM_W'(out_data.hue_div))
      else $error("hue remainder not reduced below divisor");

endmodule

### hdl/rgb_to_hsl_converter.sv
// RGB to HSL converter, top level: front end, divider pipeline, output register.
// Depends on rth_pkg, rth_prep, rth_div_pipe and rth_div_step.
//
// Takes one 8-bit RGB pixel per clock unless held off by back-pressure and gives
// hue in degrees (0..359), saturation and lightness in percent (0..100), all
// rounded to nearest with halves up; grey pixels give zero hue and saturation.
// Throughput is one pixel per cycle without back-pressure. A pixel passes two
// front-end stages, nine divider stages (one quotient bit per stage, restoring)
// and the output register. Every stage holds under back-pressure and empty
// stages fill, so input is taken while the output waits if any stage is empty.
module rgb_to_hsl_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [8:0] rsp_hue,
   output logic [6:0] rsp_saturation,
   output logic [6:0] rsp_lightness
);

   logic              prep_valid, prep_ready;
   rth_pkg::lane_type prep_data;
   logic              div_valid, div_ready;
   rth_pkg::lane_type div_data;

   logic       fin_adv;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_hue_ff, rsp_hue_in;
   logic [6:0] rsp_sat_ff, rsp_sat_in;
   logic [6:0] rsp_lit_ff;

   rth_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   rth_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign fin_adv      = !rsp_valid_ff || rsp_ready;
   assign div_ready    = fin_adv;
   assign rsp_valid_in = fin_adv ? div_valid : rsp_valid_ff;

   // a hue that rounds up to a full turn wraps to zero
   assign rsp_hue_in = (div_data.grey || div_data.hue_q >= rth_pkg::HUE_FULL)
                     ? '0 : div_data.hue_q;
   assign rsp_sat_in = div_data.grey ? '0
                     : (div_data.sat_q > rth_pkg::PCT_MAX) ? rth_pkg::PCT_MAX
                     : div_data.sat_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_adv) begin
         rsp_hue_ff <= rsp_hue_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_lit_ff <= div_data.lightness;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_lightness  = rsp_lit_ff;

   // input is only held off by a result that is waiting for its transfer
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < rth_pkg::HUE_FULL && rsp_saturation <= rth_pkg::PCT_MAX
                    && rsp_lightness <= rth_pkg::PCT_MAX)
      else $error("result field out of range");

endmodule
